/* design/rcsp_pkg.sv */
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types, character codes and line-parsing helpers for the command
// stream parser.
// ----------------------------------------------------------------------------
package rcsp_pkg;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [1:0]  SKIP_LEN  = 2'd2;
   localparam logic [31:0] MAG_CAP   = 32'h8000_0001;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   typedef enum logic [2:0] {
      PH_STAR, PH_COUNT, PH_DOLLAR, PH_LENGTH,
      PH_CONTENT, PH_SKIP, PH_IDLE, PH_BADLINE
   } parse_phase_type;

   typedef enum logic [1:0] {
      NP_WS, NP_SIGN, NP_DIGITS, NP_JUNK
   } number_phase_type;

   typedef enum logic [3:0] {
      ERR_NONE, ERR_LINE_END, ERR_BAD_STAR, ERR_BAD_DOLLAR, ERR_NO_DIGITS,
      ERR_OVERFLOW, ERR_COUNT, ERR_LENGTH, ERR_TRUNCATED
   } error_code_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic           arg_byte_valid;
      logic [7:0]     arg_byte;
      logic [30:0]    arg_index;
      logic           arg_done;
      logic           header_done;
      logic [30:0]    arg_count;
      logic           cmd_done;
      logic           error_flag;
      error_code_type error_code;
   } rsp_type;

   // per-line parse context
   typedef struct packed {
      parse_phase_type  phase;
      number_phase_type nphase;
      logic             neg;
      logic [31:0]      mag;
      error_code_type   fault;
   } line_type;

   function automatic logic is_ws(logic [7:0] c);
      return c inside {CH_SPACE, [CH_TAB:CH_CR]};
   endfunction

   // one non-terminator character of a line
   function automatic line_type line_char(line_type s, logic [7:0] c);
      line_type    r;
      logic        digit;
      logic [35:0] m;
      r     = s;
      digit = c inside {[CH_ZERO:CH_NINE]};
      // mag * 10 + digit, as shift-add
      m     = {1'b0, s.mag, 3'b000} + {3'b000, s.mag, 1'b0} + {32'd0, c[3:0]};
      case (s.phase)
         PH_STAR: begin
            if (c == CH_STAR) begin
               r.phase = PH_COUNT;
            end else begin
               r.phase = PH_BADLINE;
               r.fault = ERR_BAD_STAR;
            end
         end
         PH_DOLLAR: begin
            if (c == CH_DOLLAR) begin
               r.phase = PH_LENGTH;
            end else begin
               r.phase = PH_BADLINE;
               r.fault = ERR_BAD_DOLLAR;
            end
         end
         PH_COUNT, PH_LENGTH: begin
            if (s.nphase != NP_JUNK) begin
               if (digit) begin
                  r.mag    = (m > {4'd0, MAG_CAP}) ? MAG_CAP : m[31:0];
                  r.nphase = NP_DIGITS;
               end else if (s.nphase == NP_WS && is_ws(c)) begin
                  r.nphase = NP_WS;
               end else if (s.nphase == NP_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                  r.neg    = (c == CH_MINUS);
                  r.nphase = NP_SIGN;
               end else begin
                  if (s.nphase != NP_DIGITS) r.fault = ERR_NO_DIGITS;
                  r.nphase = NP_JUNK;
               end
            end
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

endpackage

/* design/rcsp_in_stage.sv */
// ----------------------------------------------------------------------------
// rcsp_in_stage
// Input register: holds one request byte until the parser step consumes it.
// ----------------------------------------------------------------------------
module rcsp_in_stage
   import rcsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       take,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff;
   item_type item_ff;

   // refill whenever the held request is consumed in the same cycle
   assign req_stall  = valid_ff && !take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.data_byte <= req_data_byte;
         item_ff.last_byte <= req_last_byte;
      end
   end

endmodule

/* design/rcsp_step.sv */
// ----------------------------------------------------------------------------
// rcsp_step
// Parser state and the per-byte step: line framing, number scan, argument
// content counting and end-of-buffer checks.
// ----------------------------------------------------------------------------
module rcsp_step
   import rcsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  item_type item,
   output rsp_type  result
);

   parse_phase_type  phase_ff, phase_in, phase_step;
   number_phase_type nphase_ff, nphase_in;
   logic             neg_ff, neg_in;
   logic [31:0]      mag_ff, mag_in;
   logic             cr_ff, cr_in;
   error_code_type   fault_ff, fault_in;
   logic [30:0]      args_rem_ff, args_rem_in;
   logic [30:0]      cur_arg_ff, cur_arg_in;
   logic [30:0]      content_rem_ff, content_rem_in;
   logic [1:0]       skip_ff, skip_in;

   logic [7:0]       b;
   logic             lf_hit;
   logic             cont_last;
   logic             args_last;
   logic             skip_last;
   logic             len_zero;
   error_code_type   num_fault;
   error_code_type   end_err;
   line_type         ls0, ls_cr, ls_b;

   assign b         = item.data_byte;
   assign lf_hit    = cr_ff && (b == CH_LF);
   assign cont_last = (content_rem_ff == 31'd1);
   assign args_last = (args_rem_ff == 31'd1);
   assign skip_last = (skip_ff == 2'd1);
   assign len_zero  = (mag_ff[30:0] == 31'd0);

   assign ls0   = '{phase: phase_ff, nphase: nphase_ff, neg: neg_ff, mag: mag_ff,
                    fault: fault_ff};
   // a held CR that is not followed by LF is ordinary line text
   assign ls_cr = cr_ff ? line_char(ls0, CH_CR) : ls0;
   assign ls_b  = line_char(ls_cr, b);

   always_comb begin
      if (fault_ff != ERR_NONE) begin
         num_fault = fault_ff;
      end else if (nphase_ff == NP_WS || nphase_ff == NP_SIGN) begin
         num_fault = ERR_NO_DIGITS;
      end else if (neg_ff ? (mag_ff > NEG_LIMIT) : mag_ff[31]) begin
         num_fault = ERR_OVERFLOW;
      end else begin
         num_fault = ERR_NONE;
      end
   end

   // verdict of a line at its LF
   always_comb begin
      case (phase_ff)
         PH_STAR:    end_err = ERR_BAD_STAR;
         PH_DOLLAR:  end_err = ERR_BAD_DOLLAR;
         PH_BADLINE: end_err = fault_ff;
         PH_COUNT: begin
            if (num_fault != ERR_NONE)      end_err = num_fault;
            else if (neg_ff || mag_ff == 32'd0) end_err = ERR_COUNT;
            else                            end_err = ERR_NONE;
         end
         PH_LENGTH: begin
            if (num_fault != ERR_NONE)      end_err = num_fault;
            else if (neg_ff && mag_ff != 32'd0) end_err = ERR_LENGTH;
            else                            end_err = ERR_NONE;
         end
         default:    end_err = ERR_NONE;
      endcase
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      nphase_in      = nphase_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      cr_in          = cr_ff;
      fault_in       = fault_ff;
      args_rem_in    = args_rem_ff;
      cur_arg_in     = cur_arg_ff;
      content_rem_in = content_rem_ff;
      skip_in        = skip_ff;
      case (phase_ff)
         PH_CONTENT: begin
            content_rem_in = content_rem_ff - 31'd1;
            if (cont_last) begin
               args_rem_in = args_rem_ff - 31'd1;
               if (args_last) begin
                  phase_in = PH_IDLE;
               end else begin
                  skip_in  = SKIP_LEN;
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 2'd1;
            if (skip_last) begin
               cur_arg_in = cur_arg_ff + 31'd1;
               phase_in   = PH_DOLLAR;
               nphase_in  = NP_WS;
               neg_in     = 1'b0;
               mag_in     = 32'd0;
               fault_in   = ERR_NONE;
               cr_in      = 1'b0;
            end
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            if (lf_hit) begin
               cr_in = 1'b0;
               if (end_err != ERR_NONE) begin
                  phase_in = PH_IDLE;
               end else if (phase_ff == PH_COUNT) begin
                  args_rem_in = mag_ff[30:0];
                  cur_arg_in  = 31'd0;
                  phase_in    = PH_DOLLAR;
                  nphase_in   = NP_WS;
                  neg_in      = 1'b0;
                  mag_in      = 32'd0;
                  fault_in    = ERR_NONE;
               end else begin
                  content_rem_in = mag_ff[30:0];
                  if (len_zero) begin
                     args_rem_in = args_rem_ff - 31'd1;
                     if (args_last) begin
                        phase_in = PH_IDLE;
                     end else begin
                        skip_in  = SKIP_LEN;
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     phase_in = PH_CONTENT;
                  end
               end
            end else if (b == CH_CR) begin
               phase_in  = ls_cr.phase;
               nphase_in = ls_cr.nphase;
               neg_in    = ls_cr.neg;
               mag_in    = ls_cr.mag;
               fault_in  = ls_cr.fault;
               cr_in     = 1'b1;
            end else begin
               phase_in  = ls_b.phase;
               nphase_in = ls_b.nphase;
               neg_in    = ls_b.neg;
               mag_in    = ls_b.mag;
               fault_in  = ls_b.fault;
               cr_in     = 1'b0;
            end
         end
      endcase
      phase_step = phase_in;
      // end of buffer: back to the start of a new request
      if (item.last_byte) begin
         phase_in       = PH_STAR;
         nphase_in      = NP_WS;
         neg_in         = 1'b0;
         mag_in         = 32'd0;
         cr_in          = 1'b0;
         fault_in       = ERR_NONE;
         args_rem_in    = 31'd0;
         cur_arg_in     = 31'd0;
         content_rem_in = 31'd0;
         skip_in        = 2'd0;
      end
   end

   // result of this byte
   always_comb begin
      result = '0;
      case (phase_ff)
         PH_CONTENT: begin
            result.arg_byte_valid = 1'b1;
            result.arg_byte       = b;
            result.arg_index      = cur_arg_ff;
            if (cont_last) begin
               result.arg_done = 1'b1;
               result.cmd_done = args_last;
            end
         end
         PH_SKIP, PH_IDLE: begin
            result.arg_done = 1'b0;
         end
         default: begin
            if (lf_hit) begin
               if (end_err != ERR_NONE) begin
                  result.error_flag = 1'b1;
                  result.error_code = end_err;
               end else if (phase_ff == PH_COUNT) begin
                  result.header_done = 1'b1;
                  result.arg_count   = mag_ff[30:0];
               end else if (len_zero) begin
                  result.arg_index = cur_arg_ff;
                  result.arg_done  = 1'b1;
                  result.cmd_done  = args_last;
               end
            end
         end
      endcase
      if (item.last_byte && !result.error_flag && phase_step != PH_IDLE) begin
         result.error_flag = 1'b1;
         result.error_code = (phase_step == PH_CONTENT) ? ERR_TRUNCATED : ERR_LINE_END;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STAR;
         nphase_ff      <= NP_WS;
         neg_ff         <= 1'b0;
         mag_ff         <= 32'd0;
         cr_ff          <= 1'b0;
         fault_ff       <= ERR_NONE;
         args_rem_ff    <= 31'd0;
         cur_arg_ff     <= 31'd0;
         content_rem_ff <= 31'd0;
         skip_ff        <= 2'd0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         nphase_ff      <= nphase_in;
         neg_ff         <= neg_in;
         mag_ff         <= mag_in;
         cr_ff          <= cr_in;
         fault_ff       <= fault_in;
         args_rem_ff    <= args_rem_in;
         cur_arg_ff     <= cur_arg_in;
         content_rem_ff <= content_rem_in;
         skip_ff        <= skip_in;
      end
   end

   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_ff != 2'd0))
      else $error("skip phase with no bytes left to skip");

   a_content_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CONTENT) |-> (content_rem_ff != 31'd0))
      else $error("content phase with no bytes left");

   a_cmd_with_arg: assert property (@(posedge clock) disable iff (reset)
      (fire && result.cmd_done) |-> result.arg_done)
      else $error("command done without argument done");

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && result.error_flag && !item.last_byte) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after an error");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (fire && item.last_byte) |=> (phase_ff == PH_STAR && !cr_ff))
      else $error("parser not restarted after final byte");

endmodule

/* design/rcsp_out_stage.sv */
// ----------------------------------------------------------------------------
// rcsp_out_stage
// Result register: holds one response until the receiver takes it.
// ----------------------------------------------------------------------------
module rcsp_out_stage
   import rcsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type result_in,
   output logic    ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type result_out
);

   logic    valid_ff;
   rsp_type result_ff;

   assign ready      = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign result_out = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

/* design/resp_command_stream_parser.sv */
// ----------------------------------------------------------------------------
// resp_command_stream_parser
// A request byte is accepted into the input register, then the parser step
// loads its result into the result register when that register is free.
// Throughput: one byte per cycle while the response side does not stall;
// every request byte yields exactly one response.
// Reset: synchronous; parser returns to expecting the count line, both
// registers empty. The final byte of a buffer restarts the parser likewise.
// ----------------------------------------------------------------------------
module resp_command_stream_parser
   import rcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_arg_byte_valid,
   output logic [7:0]  rsp_arg_byte,
   output logic [30:0] rsp_arg_index,
   output logic        rsp_arg_done,
   output logic        rsp_header_done,
   output logic [30:0] rsp_arg_count,
   output logic        rsp_cmd_done,
   output logic        rsp_error_flag,
   output logic [3:0]  rsp_error_code
);

   logic     item_valid;
   item_type item;
   logic     out_ready;
   logic     fire;
   rsp_type  step_result;
   rsp_type  held_result;

   assign fire = item_valid && out_ready;

   rcsp_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .take          (fire),
      .item_valid    (item_valid),
      .item          (item)
   );

   rcsp_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (step_result)
   );

   rcsp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result_in  (step_result),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result_out (held_result)
   );

   assign rsp_arg_byte_valid = held_result.arg_byte_valid;
   assign rsp_arg_byte       = held_result.arg_byte;
   assign rsp_arg_index      = held_result.arg_index;
   assign rsp_arg_done       = held_result.arg_done;
   assign rsp_header_done    = held_result.header_done;
   assign rsp_arg_count      = held_result.arg_count;
   assign rsp_cmd_done       = held_result.cmd_done;
   assign rsp_error_flag     = held_result.error_flag;
   assign rsp_error_code     = held_result.error_code;

endmodule

/* verif/resp_command_stream_parser_tb.sv */
// ----------------------------------------------------------------------------
// resp_command_stream_parser_tb
// Feeds request buffers byte by byte into the command stream parser. The
// buffers are well-formed commands with random content, broken and truncated
// commands, malformed count and length lines, and noise. A local model of the
// parser predicts the response for every accepted byte, and the monitor checks
// each response field against it. Both channels idle and stall at random, and
// the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module resp_command_stream_parser_tb;
   import rcsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 100000;
   localparam int HOLD_CYCLES  = 300;
   localparam int N_SPECIAL    = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_arg_byte_valid;
   logic [7:0]  rsp_arg_byte;
   logic [30:0] rsp_arg_index;
   logic        rsp_arg_done;
   logic        rsp_header_done;
   logic [30:0] rsp_arg_count;
   logic        rsp_cmd_done;
   logic        rsp_error_flag;
   logic [3:0]  rsp_error_code;

   resp_command_stream_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_arg_byte_valid (rsp_arg_byte_valid),
      .rsp_arg_byte       (rsp_arg_byte),
      .rsp_arg_index      (rsp_arg_index),
      .rsp_arg_done       (rsp_arg_done),
      .rsp_header_done    (rsp_header_done),
      .rsp_arg_count      (rsp_arg_count),
      .rsp_cmd_done       (rsp_cmd_done),
      .rsp_error_flag     (rsp_error_flag),
      .rsp_error_code     (rsp_error_code)
   );

   always #5 clock = ~clock;

   item_type   byte_stream_q[$];
   rsp_type    parse_results_q[$];
   bit [7:0]   frame[$];
   int         total_reqs = 0;
   int         req_sent = 0;
   int         rsp_got = 0;
   int         mismatches = 0;
   int         cycles = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;

   // ---------------------------------------------------------------------
   // parser model state
   parse_phase_type  ph;
   number_phase_type nph;
   bit               num_neg;
   bit [31:0]        num_mag;
   bit               cr_seen;
   bit [30:0]        args_left;
   bit [30:0]        arg_idx;
   bit [30:0]        bytes_left;
   bit [1:0]         skip_left;
   error_code_type   line_err;
   rsp_type          pred;

   function automatic void begin_line(parse_phase_type p);
      ph       = p;
      nph      = NP_WS;
      num_neg  = 1'b0;
      num_mag  = '0;
      line_err = ERR_NONE;
      cr_seen  = 1'b0;
   endfunction

   function automatic void reset_parser();
      begin_line(PH_STAR);
      args_left  = '0;
      arg_idx    = '0;
      bytes_left = '0;
      skip_left  = '0;
   endfunction

   function automatic void flag_error(error_code_type c);
      pred.error_flag = 1'b1;
      pred.error_code = c;
      ph              = PH_IDLE;
      cr_seen         = 1'b0;
   endfunction

   function automatic void close_arg();
      pred.arg_index = arg_idx;
      pred.arg_done  = 1'b1;
      args_left      = args_left - 31'd1;
      if (args_left == 0) begin
         pred.cmd_done = 1'b1;
         ph            = PH_IDLE;
      end else begin
         skip_left = 2'd2;
         ph        = PH_SKIP;
      end
   endfunction

   // one byte of a line that is not its terminator
   function automatic void line_byte(bit [7:0] c);
      bit [63:0] prod;
      case (ph)
         PH_STAR: begin
            if (c == CH_STAR) begin
               ph = PH_COUNT;
            end else begin
               ph       = PH_BADLINE;
               line_err = ERR_BAD_STAR;
            end
         end
         PH_DOLLAR: begin
            if (c == CH_DOLLAR) begin
               ph = PH_LENGTH;
            end else begin
               ph       = PH_BADLINE;
               line_err = ERR_BAD_DOLLAR;
            end
         end
         PH_COUNT, PH_LENGTH: begin
            if (nph != NP_JUNK) begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  prod    = num_mag * 64'd10 + (c - CH_ZERO);
                  // saturate just past the negative limit
                  num_mag = (prod > MAG_CAP) ? MAG_CAP : prod[31:0];
                  nph     = NP_DIGITS;
               end else if (nph == NP_WS && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                  nph = NP_WS;
               end else if (nph == NP_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                  num_neg = (c == CH_MINUS);
                  nph     = NP_SIGN;
               end else begin
                  if (nph != NP_DIGITS) line_err = ERR_NO_DIGITS;
                  nph = NP_JUNK;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic rsp_type parse_step(bit [7:0] b, bit last);
      error_code_type f;
      pred = '0;
      case (ph)
         PH_CONTENT: begin
            pred.arg_byte_valid = 1'b1;
            pred.arg_byte       = b;
            pred.arg_index      = arg_idx;
            bytes_left          = bytes_left - 31'd1;
            if (bytes_left == 0) close_arg();
         end
         PH_SKIP: begin
            skip_left = skip_left - 2'd1;
            if (skip_left == 0) begin
               arg_idx = arg_idx + 31'd1;
               begin_line(PH_DOLLAR);
            end
         end
         PH_IDLE: begin
         end
         default: begin
            if (cr_seen && b == CH_LF) begin
               // end of line: all line errors surface here
               cr_seen = 1'b0;
               if (ph == PH_STAR) begin
                  flag_error(ERR_BAD_STAR);
               end else if (ph == PH_DOLLAR) begin
                  flag_error(ERR_BAD_DOLLAR);
               end else if (ph == PH_BADLINE) begin
                  flag_error(line_err);
               end else begin
                  if (line_err != ERR_NONE) f = line_err;
                  else if (nph == NP_WS || nph == NP_SIGN) f = ERR_NO_DIGITS;
                  else if (num_neg ? (num_mag > NEG_LIMIT) : (num_mag > 32'h7FFF_FFFF))
                     f = ERR_OVERFLOW;
                  else f = ERR_NONE;
                  if (f != ERR_NONE) begin
                     flag_error(f);
                  end else if (ph == PH_COUNT) begin
                     if (num_neg || num_mag == 0) begin
                        flag_error(ERR_COUNT);
                     end else begin
                        pred.header_done = 1'b1;
                        pred.arg_count   = num_mag[30:0];
                        args_left        = num_mag[30:0];
                        arg_idx          = '0;
                        begin_line(PH_DOLLAR);
                     end
                  end else if (num_neg && num_mag != 0) begin
                     flag_error(ERR_LENGTH);
                  end else begin
                     bytes_left = num_mag[30:0];
                     if (bytes_left == 0) close_arg();
                     else ph = PH_CONTENT;
                  end
               end
            end else begin
               // a lone cr is ordinary line text
               if (cr_seen) begin
                  cr_seen = 1'b0;
                  line_byte(CH_CR);
               end
               if (b == CH_CR) cr_seen = 1'b1;
               else line_byte(b);
            end
         end
      endcase
      if (last) begin
         if (!pred.error_flag && ph != PH_IDLE) begin
            if (ph == PH_CONTENT) flag_error(ERR_TRUNCATED);
            else flag_error(ERR_LINE_END);
         end
         reset_parser();
      end
      return pred;
   endfunction

   // ---------------------------------------------------------------------
   // buffer building
   function automatic void put_byte(bit [7:0] v);
      frame.insert(frame.size(), v);
   endfunction

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void put_eol();
      put_byte(CH_CR);
      put_byte(CH_LF);
   endfunction

   // decimal number with random lenient formatting around it
   function automatic void put_number(longint v);
      int        k;
      bit [7:0]  w;
      if ($urandom_range(0, 3) == 0) begin
         k = $urandom_range(1, 2);
         repeat (k) begin
            w = ($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
            put_byte(w);
            if (w == CH_CR) put_byte(CH_SPACE);
         end
      end
      if (v < 0) put_byte(CH_MINUS);
      else if ($urandom_range(0, 4) == 0) put_byte(CH_PLUS);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
      put_str($sformatf("%0d", (v < 0) ? -v : v));
      k = $urandom_range(0, 7);
      if (k == 0) begin
         put_str("x");
      end else if (k == 1) begin
         put_byte(CH_SPACE);
         put_str("7");
      end else if (k == 2) begin
         put_byte(CH_CR);
         put_str("q");
      end
   endfunction

   function automatic void send_frame();
      item_type it;
      for (int i = 0; i < frame.size(); i++) begin
         it.data_byte = frame[i];
         it.last_byte = (i == frame.size() - 1);
         byte_stream_q.insert(byte_stream_q.size(), it);
      end
      frame.delete();
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   always @(posedge clock) begin : driver
      item_type nxt;
      int       idle_pct;
      bit       took;
      if (req_sent < total_reqs / 3) idle_pct = 34;
      else if (req_sent < 2 * total_reqs / 3) idle_pct = 74;
      else idle_pct = 0;
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= '0;
         req_last_byte <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            parse_results_q.insert(parse_results_q.size(),
                                   parse_step(req_data_byte, req_last_byte));
            req_sent++;
         end
         if (req_valid && !took) begin
            // stalled request holds its payload
         end else if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            nxt = byte_stream_q.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= nxt.data_byte;
            req_last_byte <= nxt.last_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long back-pressure stretch, once, early in the run
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!reset && !hold_done && total_reqs != 0 && rsp_got >= total_reqs / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      int      stall_pct;
      if (rsp_got < total_reqs / 3) stall_pct = 74;
      else if (rsp_got < 2 * total_reqs / 3) stall_pct = 34;
      else stall_pct = 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_got++;
            if (parse_results_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = parse_results_q.pop_front();
               check_field("arg_byte_valid", 32'(want.arg_byte_valid),
                           32'(rsp_arg_byte_valid));
               check_field("arg_byte", 32'(want.arg_byte), 32'(rsp_arg_byte));
               check_field("arg_index", 32'(want.arg_index), 32'(rsp_arg_index));
               check_field("arg_done", 32'(want.arg_done), 32'(rsp_arg_done));
               check_field("header_done", 32'(want.header_done), 32'(rsp_header_done));
               check_field("arg_count", 32'(want.arg_count), 32'(rsp_arg_count));
               check_field("cmd_done", 32'(want.cmd_done), 32'(rsp_cmd_done));
               check_field("error_flag", 32'(want.error_flag), 32'(rsp_error_flag));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   initial begin
      int spec;
      int n;
      int len;
      int k;
      reset_parser();

      // empty argument completes the command, trailing byte ignored
      put_str("*1");
      put_eol();
      put_str("$0");
      put_eol();
      put_str("z");
      send_frame();
      // empty count line
      put_eol();
      send_frame();
      // buffer ends inside the count line
      put_str("x");
      send_frame();
      // buffer ends inside content, last byte still delivered
      put_str("*1");
      put_eol();
      put_str("$2");
      put_eol();
      put_byte(8'hFF);
      send_frame();

      spec = 0;
      while (byte_stream_q.size() < 500 || spec < N_SPECIAL) begin
         if (spec < N_SPECIAL) begin
            case (spec % N_SPECIAL)
               0: begin
                  put_byte(CH_STAR);
                  put_number(64'd2147483648);
                  put_eol();
               end
               1: begin
                  put_byte(CH_STAR);
                  put_number(-64'd2147483648);
                  put_eol();
               end
               2: begin
                  put_byte(CH_STAR);
                  put_number(64'd0);
                  put_eol();
               end
               3: begin
                  put_byte(CH_STAR);
                  put_number(-64'sd3);
                  put_eol();
               end
               4: begin
                  put_str("*+");
                  put_eol();
               end
               5: begin
                  put_str("#1");
                  put_eol();
                  put_str("xy");
               end
               6: begin
                  put_str("*1");
                  put_eol();
                  put_eol();
               end
               7: begin
                  put_str("*1");
                  put_eol();
                  put_byte(CH_DOLLAR);
                  put_number(-64'sd1);
                  put_eol();
               end
               8: begin
                  put_str("*2");
                  put_eol();
                  put_byte(CH_DOLLAR);
                  put_number(64'd99999999999);
                  put_eol();
               end
               9: begin
                  put_str("*1");
                  put_eol();
                  put_byte(CH_DOLLAR);
                  put_eol();
               end
               10: begin
                  put_str("*1");
                  put_eol();
                  put_byte(CH_DOLLAR);
                  put_number(64'd2147483647);
                  put_eol();
                  repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
               end
               11: begin
                  // ends inside the two skipped bytes
                  put_str("*2");
                  put_eol();
                  put_str("$1");
                  put_eol();
                  put_str("q");
                  put_byte(CH_CR);
               end
               12: begin
                  put_str("*1");
                  put_eol();
                  put_byte(CH_DOLLAR);
                  put_number(-64'd2147483648);
                  put_eol();
               end
               13: begin
                  put_byte(CH_STAR);
                  put_number(64'd2147483647);
                  put_eol();
                  put_str("$0");
                  put_eol();
               end
               14: begin
                  put_str("*1");
                  put_eol();
                  put_str("$1");
                  put_byte(CH_CR);
               end
               default: begin
                  // negative zero length is an empty argument
                  put_str("*1");
                  put_eol();
                  put_str("$-0");
                  put_eol();
               end
            endcase
            spec++;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
            put_byte(CH_STAR);
            put_number(longint'(n));
            put_eol();
            for (int a = 0; a < n; a++) begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
               put_byte(CH_DOLLAR);
               put_number(longint'(len));
               put_eol();
               repeat (len) put_byte(8'($urandom_range(0, 255)));
               if (a < n - 1 || $urandom_range(0, 1) == 1) begin
                  if ($urandom_range(0, 9) < 7) put_eol();
                  else repeat (2) put_byte(8'($urandom_range(0, 255)));
               end
            end
            k = $urandom_range(0, 9);
            if (k == 0) begin
               len = $urandom_range(1, frame.size());
               while (frame.size() > len) void'(frame.pop_back());
            end else if (k == 1) begin
               frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (k == 2) begin
               frame.delete();
               repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
            end
         end
         repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
         send_frame();
      end
      total_reqs = byte_stream_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (byte_stream_q.size() != 0 || req_valid) @(posedge clock);
      while (parse_results_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
design/rcsp_pkg.sv
design/rcsp_in_stage.sv
design/rcsp_step.sv
design/rcsp_out_stage.sv
design/resp_command_stream_parser.sv
verif/resp_command_stream_parser_tb.sv
